// ===== rtl/core/bble_pkg.sv =====
// Shared constants, codes and control/status structs for the banked list engine.
// Used by bble_ctrl, bble_dp and banked_bounded_list_engine.
package bble_pkg;

    localparam int NUM_BANKS = 10;
    localparam int MAX_DEPTH = 16;
    localparam int BANK_W    = 4;
    localparam int VALUE_W   = 32;
    localparam int AMT_W     = 8;
    localparam int CNT_OUT_W = 5;
    localparam int BSEL_W    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_BANKS * MAX_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_POP    = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_READ   = 3'd4,
        CMD_SORTED = 3'd5,
        CMD_RESIZE = 3'd6,
        CMD_COUNT  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOBANK   = 3'd2,
        ST_EXISTS   = 3'd3,
        ST_BADBANK  = 3'd4,
        ST_BADSIZE  = 3'd5,
        ST_EMPTY    = 3'd6,
        ST_NOTFOUND = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        OSEL_SINGLE,
        OSEL_NOTFOUND,
        OSEL_REMOVED,
        OSEL_ELEM,
        OSEL_BEST
    } t_osel;

    typedef struct packed {
        logic  load;
        logic  apply;
        logic  ptr_clr;
        logic  ptr_inc;
        logic  j_take;
        logic  j_inc;
        logic  rd_en;
        logic  rd_next;
        logic  sh_wr;
        logic  rm_commit;
        logic  best_clr;
        logic  best_upd;
        logic  prev_take;
        logic  out_ld;
        t_osel osel;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic multi;
        logic out_free;
        logic match;
        logic ptr_last;
        logic j_last;
        logic k_last;
    } t_sts;

endpackage

// ===== rtl/core/bble_dp.sv =====
// Datapath of the banked list engine: request registers, per-bank count and
// capacity, element memory, scan pointers and the output register. Uses bble_pkg.
module bble_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bble_pkg::t_ctl                    i_ctl,
    output bble_pkg::t_sts                    o_sts,
    input  logic [2:0]                        i_cmd,
    input  logic [bble_pkg::BANK_W-1:0]       i_bank,
    input  logic signed [bble_pkg::VALUE_W-1:0] i_value,
    input  logic signed [bble_pkg::AMT_W-1:0] i_amount,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [2:0]                        o_status,
    output logic signed [bble_pkg::VALUE_W-1:0] o_data,
    output logic [bble_pkg::CNT_OUT_W-1:0]    o_count,
    output logic                              o_last
);
    localparam int NS_W = bble_pkg::CNT_W + 9;

    bble_pkg::t_cmd                        r_cmd;
    logic [bble_pkg::BANK_W-1:0]           r_bank;
    logic signed [bble_pkg::VALUE_W-1:0]   r_value;
    logic signed [bble_pkg::AMT_W-1:0]     r_amount;

    logic [bble_pkg::CNT_W-1:0] r_cnt_a [bble_pkg::NUM_BANKS];
    logic [bble_pkg::CNT_W-1:0] r_cap_a [bble_pkg::NUM_BANKS];

    logic signed [bble_pkg::VALUE_W-1:0] r_mem [bble_pkg::MEM_DEPTH];
    logic signed [bble_pkg::VALUE_W-1:0] r_rdata;

    logic [bble_pkg::CNT_W-1:0] r_ptr, r_j, r_k, r_bi, r_pi;
    logic signed [bble_pkg::VALUE_W-1:0] r_bv, r_pv;
    logic r_bvalid, r_have_prev;

    logic r_ovalid;
    logic [2:0] r_ostatus;
    logic signed [bble_pkg::VALUE_W-1:0] r_odata;
    logic [bble_pkg::CNT_OUT_W-1:0] r_ocount;
    logic r_olast;

    logic bank_ok;
    logic [bble_pkg::BSEL_W-1:0] sel;
    logic [bble_pkg::CNT_W-1:0] cnt, cap;
    logic [bble_pkg::ADDR_W-1:0] base, raddr, waddr;
    logic signed [bble_pkg::VALUE_W-1:0] wdata;
    logic we;
    logic signed [NS_W-1:0] amt_w, cap_w, ns;
    bble_pkg::t_status s_status;
    logic [bble_pkg::CNT_W-1:0] s_count, n_cnt, n_cap;
    logic s_we_cnt, s_we_cap, s_app;
    logic gt_prev, better;
    logic out_free;

    assign bank_ok = ({1'b0, r_bank} < (bble_pkg::BANK_W + 1)'(bble_pkg::NUM_BANKS));
    assign sel     = r_bank[bble_pkg::BSEL_W-1:0];
    assign cnt     = bank_ok ? r_cnt_a[sel] : '0;
    assign cap     = bank_ok ? r_cap_a[sel] : '0;
    assign base    = bble_pkg::ADDR_W'(sel) * bble_pkg::ADDR_W'(bble_pkg::MAX_DEPTH);
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        amt_w    = NS_W'(r_amount);
        cap_w    = NS_W'({1'b0, cap});
        ns       = cap_w + amt_w;
        s_status = bble_pkg::ST_OK;
        s_count  = cnt;
        n_cnt    = cnt;
        n_cap    = cap;
        s_we_cnt = 1'b0;
        s_we_cap = 1'b0;
        s_app    = 1'b0;
        if (!bank_ok) begin
            s_status = bble_pkg::ST_BADBANK;
            s_count  = '0;
        end else if (r_cmd == bble_pkg::CMD_CREATE) begin
            if (amt_w < NS_W'(1) || amt_w > NS_W'(bble_pkg::MAX_DEPTH)) begin
                s_status = bble_pkg::ST_BADSIZE;
            end else if (cap != '0) begin
                s_status = bble_pkg::ST_EXISTS;
            end else begin
                n_cap    = bble_pkg::CNT_W'(amt_w);
                n_cnt    = '0;
                s_count  = '0;
                s_we_cnt = 1'b1;
                s_we_cap = 1'b1;
            end
        end else if (r_cmd == bble_pkg::CMD_RESIZE) begin
            if (ns < NS_W'(1) || ns > NS_W'(bble_pkg::MAX_DEPTH)) begin
                s_status = bble_pkg::ST_BADSIZE;
            end else if (cap == '0) begin
                s_status = bble_pkg::ST_NOBANK;
            end else begin
                n_cap    = bble_pkg::CNT_W'(ns);
                if (cnt > bble_pkg::CNT_W'(ns)) n_cnt = bble_pkg::CNT_W'(ns);
                s_count  = n_cnt;
                s_we_cnt = 1'b1;
                s_we_cap = 1'b1;
            end
        end else if (cap == '0) begin
            s_status = bble_pkg::ST_NOBANK;
        end else begin
            unique case (r_cmd)
                bble_pkg::CMD_APPEND: begin
                    if (cnt >= cap) begin
                        s_status = bble_pkg::ST_FULL;
                    end else begin
                        n_cnt    = cnt + 1'b1;
                        s_count  = n_cnt;
                        s_we_cnt = 1'b1;
                        s_app    = 1'b1;
                    end
                end
                bble_pkg::CMD_POP: begin
                    if (cnt == '0) begin
                        s_status = bble_pkg::ST_EMPTY;
                    end else begin
                        n_cnt    = cnt - 1'b1;
                        s_count  = n_cnt;
                        s_we_cnt = 1'b1;
                    end
                end
                default: begin
                    if (cnt == '0) s_status = bble_pkg::ST_EMPTY;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.multi    = bank_ok && cap != '0 && cnt != '0 &&
                         (r_cmd == bble_pkg::CMD_REMOVE || r_cmd == bble_pkg::CMD_READ ||
                          r_cmd == bble_pkg::CMD_SORTED);
        o_sts.out_free = out_free;
        o_sts.match    = (r_rdata == r_value);
        o_sts.ptr_last = (r_ptr + 1'b1 >= cnt);
        o_sts.j_last   = (r_j + 2'd2 >= cnt);
        o_sts.k_last   = (r_k + 1'b1 >= cnt);
    end

    assign gt_prev = !r_have_prev || (r_rdata > r_pv) || (r_rdata == r_pv && r_ptr > r_pi);
    assign better  = !r_bvalid || (r_rdata < r_bv);

    assign raddr = base + bble_pkg::ADDR_W'(i_ctl.rd_next ? r_j[bble_pkg::IDX_W-1:0] + 1'b1
                                                           : r_ptr[bble_pkg::IDX_W-1:0]);
    assign waddr = base + bble_pkg::ADDR_W'(i_ctl.sh_wr ? r_j[bble_pkg::IDX_W-1:0]
                                                         : cnt[bble_pkg::IDX_W-1:0]);
    assign wdata = i_ctl.sh_wr ? r_rdata : r_value;
    assign we    = i_ctl.sh_wr || (i_ctl.apply && s_app);

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (i_ctl.rd_en) r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= bble_pkg::t_cmd'(i_cmd);
            r_bank   <= i_bank;
            r_value  <= i_value;
            r_amount <= i_amount;
        end
        if (i_ctl.load || i_ctl.ptr_clr) r_ptr <= '0;
        else if (i_ctl.ptr_inc) r_ptr <= r_ptr + 1'b1;
        if (i_ctl.j_take) r_j <= r_ptr;
        else if (i_ctl.j_inc) r_j <= r_j + 1'b1;
        if (i_ctl.best_upd && gt_prev && better) begin
            r_bv <= r_rdata;
            r_bi <= r_ptr;
        end
        if (i_ctl.prev_take) begin
            r_pv <= r_bv;
            r_pi <= r_bi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < bble_pkg::NUM_BANKS; b++) begin
                r_cnt_a[b] <= '0;
                r_cap_a[b] <= '0;
            end
            r_ovalid    <= 1'b0;
            r_bvalid    <= 1'b0;
            r_have_prev <= 1'b0;
            r_k         <= '0;
        end else begin
            if (i_ctl.apply && s_we_cnt) r_cnt_a[sel] <= n_cnt;
            if (i_ctl.apply && s_we_cap) r_cap_a[sel] <= n_cap;
            if (i_ctl.rm_commit) r_cnt_a[sel] <= cnt - 1'b1;
            if (i_ctl.load) begin
                r_have_prev <= 1'b0;
                r_k         <= '0;
            end else if (i_ctl.prev_take) begin
                r_have_prev <= 1'b1;
                r_k         <= r_k + 1'b1;
            end
            if (i_ctl.best_clr) r_bvalid <= 1'b0;
            else if (i_ctl.best_upd && gt_prev) r_bvalid <= 1'b1;
            if (i_ctl.out_ld) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_ld) begin
            r_odata <= '0;
            r_olast <= 1'b1;
            r_ocount <= bble_pkg::CNT_OUT_W'(cnt);
            unique case (i_ctl.osel)
                bble_pkg::OSEL_SINGLE: begin
                    r_ostatus <= s_status;
                    r_ocount  <= bble_pkg::CNT_OUT_W'(s_count);
                end
                bble_pkg::OSEL_NOTFOUND: r_ostatus <= bble_pkg::ST_NOTFOUND;
                bble_pkg::OSEL_REMOVED: begin
                    r_ostatus <= bble_pkg::ST_OK;
                    r_ocount  <= bble_pkg::CNT_OUT_W'(cnt - 1'b1);
                end
                bble_pkg::OSEL_ELEM: begin
                    r_ostatus <= bble_pkg::ST_OK;
                    r_odata   <= r_rdata;
                    r_olast   <= o_sts.ptr_last;
                end
                default: begin
                    r_ostatus <= bble_pkg::ST_OK;
                    r_odata   <= r_bv;
                    r_olast   <= o_sts.k_last;
                end
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;
    assign o_data   = r_odata;
    assign o_count  = r_ocount;
    assign o_last   = r_olast;

    a_cnt_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bank_ok |-> cnt <= cap)
        else $error("bank count above capacity");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.out_ld |-> out_free)
        else $error("result overwritten before taken");
    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.sh_wr |-> r_j + 1'b1 < cnt)
        else $error("shift write beyond bank contents");
    a_sorted_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.prev_take |-> r_bvalid)
        else $error("sorted result without a candidate");
endmodule

// ===== rtl/core/bble_ctrl.sv =====
// Command sequencer of the banked list engine: accepts requests and steps the
// datapath through single results, remove shifts and read runs. Uses bble_pkg.
module bble_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bble_pkg::t_sts i_sts,
    output bble_pkg::t_ctl o_ctl
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RM_RD, S_RM_CMP, S_SH_RD, S_SH_WR, S_RM_FIN,
        S_RD_RD, S_RD_OUT, S_SR_START, S_SR_RD, S_SR_CMP, S_SR_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.osel = bble_pkg::OSEL_SINGLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.multi) begin
                    priority case (i_sts.cmd)
                        bble_pkg::CMD_REMOVE: n_state = S_RM_RD;
                        bble_pkg::CMD_READ:   n_state = S_RD_RD;
                        default:              n_state = S_SR_START;
                    endcase
                end else if (i_sts.out_free) begin
                    o_ctl.apply  = 1'b1;
                    o_ctl.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RM_RD: begin
                o_ctl.rd_en = 1'b1;
                n_state = S_RM_CMP;
            end
            S_RM_CMP: begin
                if (i_sts.match) begin
                    o_ctl.j_take = 1'b1;
                    n_state = i_sts.ptr_last ? S_RM_FIN : S_SH_RD;
                end else if (!i_sts.ptr_last) begin
                    o_ctl.ptr_inc = 1'b1;
                    n_state = S_RM_RD;
                end else if (i_sts.out_free) begin
                    o_ctl.out_ld = 1'b1;
                    o_ctl.osel   = bble_pkg::OSEL_NOTFOUND;
                    n_state = S_IDLE;
                end
            end
            S_SH_RD: begin
                o_ctl.rd_en   = 1'b1;
                o_ctl.rd_next = 1'b1;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                o_ctl.sh_wr = 1'b1;
                o_ctl.j_inc = 1'b1;
                n_state = i_sts.j_last ? S_RM_FIN : S_SH_RD;
            end
            S_RM_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.rm_commit = 1'b1;
                    o_ctl.out_ld    = 1'b1;
                    o_ctl.osel      = bble_pkg::OSEL_REMOVED;
                    n_state = S_IDLE;
                end
            end
            S_RD_RD: begin
                o_ctl.rd_en = 1'b1;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_ld = 1'b1;
                    o_ctl.osel   = bble_pkg::OSEL_ELEM;
                    if (i_sts.ptr_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctl.ptr_inc = 1'b1;
                        n_state = S_RD_RD;
                    end
                end
            end
            S_SR_START: begin
                o_ctl.ptr_clr  = 1'b1;
                o_ctl.best_clr = 1'b1;
                n_state = S_SR_RD;
            end
            S_SR_RD: begin
                o_ctl.rd_en = 1'b1;
                n_state = S_SR_CMP;
            end
            S_SR_CMP: begin
                o_ctl.best_upd = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_SR_OUT;
                end else begin
                    o_ctl.ptr_inc = 1'b1;
                    n_state = S_SR_RD;
                end
            end
            S_SR_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_ld    = 1'b1;
                    o_ctl.osel      = bble_pkg::OSEL_BEST;
                    o_ctl.prev_take = 1'b1;
                    n_state = i_sts.k_last ? S_IDLE : S_SR_START;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> r_state == S_DECIDE)
        else $error("request load did not start decode");
    a_no_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_ctl.sh_wr && !o_ctl.apply && !o_ctl.out_ld)
        else $error("datapath action while idle");
    a_shift_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.sh_wr |-> $past(o_ctl.rd_en && o_ctl.rd_next))
        else $error("shift write without preceding read");
endmodule

// ===== rtl/core/banked_bounded_list_engine.sv =====
// Banked list engine: NUM_BANKS bounded lists in one element memory with one
// read port (bank b at b*MAX_DEPTH). One request at a time; create, append, pop,
// resize and count are answered from one decode, a read returns the elements
// one by one, a remove scans for the value and shifts later elements down, and a
// sorted read rescans the bank for each element it returns, as the one read port
// allows. Results wait while held off. Uses bble_pkg, bble_ctrl and bble_dp.
module banked_bounded_list_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_cmd,
    input  logic [bble_pkg::BANK_W-1:0]         i_bank,
    input  logic signed [bble_pkg::VALUE_W-1:0] i_value,
    input  logic signed [bble_pkg::AMT_W-1:0]   i_amount,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_status,
    output logic signed [bble_pkg::VALUE_W-1:0] o_data,
    output logic [bble_pkg::CNT_OUT_W-1:0]      o_count,
    output logic                                o_last
);
    bble_pkg::t_ctl ctl;
    bble_pkg::t_sts sts;

    bble_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    bble_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .i_cmd    (i_cmd),
        .i_bank   (i_bank),
        .i_value  (i_value),
        .i_amount (i_amount),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_data   (o_data),
        .o_count  (o_count),
        .o_last   (o_last)
    );
endmodule
